// File: rtl/core/setc_pkg.sv
// Shared types, constants and the rate lookup for the sampling epoch time calculator.
`timescale 1ns / 1ps
package setc_pkg;

   // One GPS week in nanoseconds; the upper part is the week with 16 low zero bits removed.
   localparam logic [49:0] WEEK_NS       = 50'd604800000000000;
   localparam logic [33:0] WEEK_NS_HI    = 34'd9228515625;
   localparam int          WEEK_SHIFT    = 16;
   localparam logic signed [16:0] MAX_WEEK_DIFF = 17'sd15250;

   // Divider geometry: the dividend is taken 7 bits down, so the divisor fits 23 bits.
   localparam int LOW_W      = 7;
   localparam int DIVR_W     = 23;
   localparam int QUO_W      = 39;
   localparam int NUM_W      = 56;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;

   typedef enum logic [1:0] {
      KIND_TIME  = 2'd0,
      KIND_INDEX = 2'd1,
      KIND_COUNT = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_RATE = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_BAD_DUR  = 2'd3
   } status_type;

   localparam logic [1:0] CSR_START_WEEK = 2'd0;
   localparam logic [1:0] CSR_START_TOW  = 2'd1;
   localparam logic [1:0] CSR_RATE       = 2'd2;

   typedef struct packed {
      kind_type           kind;
      logic [47:0]        epoch_number;
      logic [15:0]        event_week;
      logic [49:0]        event_tow_ns;
      logic signed [63:0] duration;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] result_week;
      logic [49:0] result_tow_ns;
      logic [38:0] result_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] start_week;
      logic [49:0] start_tow_ns;
      logic [5:0]  rate_hz;
   } csr_type;

   // Per-word bookkeeping that rides along the divider.
   typedef struct packed {
      kind_type        kind;
      status_type      status;
      logic            zero;
      logic [LOW_W-1:0] low;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [DIVR_W-1:0] rem;
      logic [QUO_W-1:0]  nq;
      logic [DIVR_W-1:0] divisor;
   } div_type;

   typedef struct packed {
      logic              ok;
      logic [29:0]       interval;
      logic [DIVR_W-1:0] div_time;
      logic [DIVR_W-1:0] div_count;
      logic [38:0]       idx_limit;
   } rate_info_type;

   // div_time is the epochs per week over 128, div_count the interval over 128.
   function automatic rate_info_type rate_info(input logic [5:0] rate);
      rate_info_type r;
      r = '0;
      unique case (rate)
         6'd1: begin
            r = '{1'b1, 30'd1000000000, 23'd4725, 23'd7812500, 39'd9223372036};
         end
         6'd5: begin
            r = '{1'b1, 30'd200000000, 23'd23625, 23'd1562500, 39'd46116860184};
         end
         6'd10: begin
            r = '{1'b1, 30'd100000000, 23'd47250, 23'd781250, 39'd92233720368};
         end
         6'd20: begin
            r = '{1'b1, 30'd50000000, 23'd94500, 23'd390625, 39'd184467440737};
         end
         6'd50: begin
            r = '{1'b1, 30'd20000000, 23'd236250, 23'd156250, 39'd461168601842};
         end
         default: begin
            r = '0;
         end
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/setc_front.sv
// Front stages: request checks, week difference product, and divider operand setup.
`timescale 1ns / 1ps
module setc_front import setc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   typedef struct packed {
      kind_type           kind;
      status_type         status;
      logic [63:0]        num;
      logic signed [50:0] prod;
      logic signed [50:0] towd;
      logic [DIVR_W-1:0]  divisor;
   } front_type;

   localparam logic signed [67:0] Y_MAX = 68'sd9223372036854775806;
   localparam logic signed [67:0] Y_MIN = -68'sd9223372036854775809;

   logic               v1_ff, v2_ff;
   front_type          f1_ff, f1_in;
   div_type            f2_ff, f2_in;
   logic               load1, load2;
   rate_info_type      ri;
   logic               st_bad;
   logic signed [16:0] wd;
   logic signed [67:0] y;
   logic [NUM_W-1:0]   dvd;
   status_type         st2;

   assign load2    = !v2_ff || out_ready;
   assign load1    = !v1_ff || load2;
   assign in_ready = load1;

   // Stage one: classify the request and start the week product.
   always_comb begin
      ri     = rate_info(csr.rate_hz);
      st_bad = csr.start_tow_ns >= WEEK_NS;
      wd     = $signed({1'b0, in_data.event_week}) - $signed({1'b0, csr.start_week});
      f1_in  = '0;
      f1_in.kind   = in_data.kind;
      f1_in.status = STATUS_OK;
      f1_in.prod   = wd * $signed({1'b0, WEEK_NS_HI});
      f1_in.towd   = $signed({1'b0, in_data.event_tow_ns}) - $signed({1'b0, csr.start_tow_ns});
      unique case (in_data.kind)
         KIND_TIME: begin
            f1_in.num     = {16'd0, in_data.epoch_number};
            f1_in.divisor = ri.div_time;
            if (!ri.ok) begin
               f1_in.status = STATUS_BAD_RATE;
            end else if (in_data.epoch_number > 48'(ri.idx_limit) || st_bad) begin
               f1_in.status = STATUS_RANGE;
            end
         end
         KIND_INDEX: begin
            f1_in.divisor = ri.div_count;
            if (!ri.ok) begin
               f1_in.status = STATUS_BAD_RATE;
            end else if (in_data.event_tow_ns >= WEEK_NS || st_bad ||
                         wd > MAX_WEEK_DIFF || wd < -MAX_WEEK_DIFF) begin
               f1_in.status = STATUS_RANGE;
            end
         end
         KIND_COUNT: begin
            f1_in.num     = in_data.duration - 64'd1;
            f1_in.divisor = ri.div_count;
            if ($signed(in_data.duration) <= 64'sd0) begin
               f1_in.status = STATUS_BAD_DUR;
            end else if (!ri.ok) begin
               f1_in.status = STATUS_BAD_RATE;
            end
         end
         KIND_NONE: begin
            f1_in.divisor = ri.div_count;
         end
      endcase
   end

   // Stage two: form the event difference less one, check its range, pick the dividend.
   always_comb begin
      y   = ($signed(68'($signed(f1_ff.prod))) <<< WEEK_SHIFT)
            + 68'($signed(f1_ff.towd)) - 68'sd1;
      st2 = f1_ff.status;
      dvd = '0;
      f2_in = '0;
      unique case (f1_ff.kind)
         KIND_TIME: begin
            dvd = NUM_W'(f1_ff.num[47:LOW_W]);
         end
         KIND_INDEX: begin
            dvd = y[62:LOW_W];
            if (st2 == STATUS_OK && (y > Y_MAX || y < Y_MIN)) begin
               st2 = STATUS_RANGE;
            end
            f2_in.side.zero = y < 68'sd0;
         end
         KIND_COUNT: begin
            dvd = f1_ff.num[62:LOW_W];
         end
         KIND_NONE: begin
            f2_in.side.zero = 1'b1;
         end
      endcase
      f2_in.side.kind   = f1_ff.kind;
      f2_in.side.status = st2;
      f2_in.side.low    = f1_ff.num[LOW_W-1:0];
      f2_in.rem         = DIVR_W'(dvd[NUM_W-1:QUO_W]);
      f2_in.nq          = dvd[QUO_W-1:0];
      f2_in.divisor     = f1_ff.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (load1) begin
            v1_ff <= in_valid;
         end
         if (load2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load1 && in_valid) begin
         f1_ff <= f1_in;
      end
      if (load2 && v1_ff) begin
         f2_ff <= f2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = f2_ff;

endmodule

// File: rtl/core/setc_div.sv
// One stage of the restoring divider: a few quotient bits per word.
`timescale 1ns / 1ps
module setc_div import setc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic            v_ff;
   div_type         d_ff, d_in;
   logic            load;
   logic [DIVR_W:0] sh;
   logic            qb;

   assign load     = !v_ff || out_ready;
   assign in_ready = load;

   // Each step shifts a dividend bit into the remainder; subtract if it fits.
   always_comb begin
      d_in = in_data;
      sh   = '0;
      qb   = 1'b0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         sh = {d_in.rem, d_in.nq[QUO_W-1]};
         qb = sh >= {1'b0, d_in.divisor};
         if (qb) begin
            d_in.rem = DIVR_W'(sh - {1'b0, d_in.divisor});
         end else begin
            d_in.rem = sh[DIVR_W-1:0];
         end
         d_in.nq = {d_in.nq[QUO_W-2:0], qb};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (load) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

// File: rtl/core/setc_back.sv
// Back stages: time of week rebuild, week carry, count, and the output register.
`timescale 1ns / 1ps
module setc_back import setc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   typedef struct packed {
      side_type    side;
      logic [49:0] part;
      logic [17:0] week;
      logic        q_big;
      logic [38:0] count;
   } back_type;

   logic          v1_ff, vo_ff;
   back_type      b1_ff, b1_in;
   rsp_type       rsp_ff, rsp_in;
   logic          load1, load_out;
   rate_info_type ri;
   logic [24:0]   rem_full;
   logic [54:0]   prod;
   logic [50:0]   tow_sum;
   logic [49:0]   tow;
   logic [18:0]   week;
   logic          wrap;
   status_type    st;

   assign load_out = !vo_ff || out_ready;
   assign load1    = !v1_ff || load_out;
   assign in_ready = load1;

   // Remainder of the epoch index rescaled to nanoseconds within the week.
   always_comb begin
      ri       = rate_info(csr.rate_hz);
      rem_full = {in_data.rem[17:0], in_data.side.low};
      prod     = rem_full * ri.interval;
      b1_in.side  = in_data.side;
      b1_in.part  = prod[49:0];
      b1_in.week  = 18'(csr.start_week) + 18'(in_data.nq[16:0]);
      b1_in.q_big = |in_data.nq[QUO_W-1:17];
      b1_in.count = in_data.nq + 39'd1;
   end

   always_comb begin
      tow_sum = 51'(csr.start_tow_ns) + 51'(b1_ff.part);
      wrap    = tow_sum >= {1'b0, WEEK_NS};
      tow     = wrap ? 50'(tow_sum - {1'b0, WEEK_NS}) : tow_sum[49:0];
      week    = {1'b0, b1_ff.week} + 19'(wrap);
      st      = b1_ff.side.status;
      if (b1_ff.side.kind == KIND_TIME && st == STATUS_OK &&
          (b1_ff.q_big || (|week[18:16]))) begin
         st = STATUS_RANGE;
      end
      rsp_in        = '0;
      rsp_in.status = st;
      if (st == STATUS_OK && !b1_ff.side.zero) begin
         unique case (b1_ff.side.kind)
            KIND_TIME: begin
               rsp_in.result_week   = week[15:0];
               rsp_in.result_tow_ns = tow;
            end
            KIND_INDEX, KIND_COUNT: begin
               rsp_in.result_count = b1_ff.count;
            end
            KIND_NONE: begin
               rsp_in.result_count = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (load1) begin
            v1_ff <= in_valid;
         end
         if (load_out) begin
            vo_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load1 && in_valid) begin
         b1_ff <= b1_in;
      end
      if (load_out && v1_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_data  = rsp_ff;

   a_tow_normalized: assert property (@(posedge clock) disable iff (reset)
      vo_ff |-> rsp_ff.result_tow_ns < WEEK_NS)
      else $error("time of week out of range");

   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      vo_ff && rsp_ff.status != STATUS_OK |->
         rsp_ff.result_week == 16'd0 && rsp_ff.result_tow_ns == 50'd0 &&
         rsp_ff.result_count == 39'd0)
      else $error("error word carries data");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      vo_ff && !out_ready |=> vo_ff && $stable(rsp_ff))
      else $error("output word changed under stall");

endmodule

// File: rtl/core/sampling_epoch_time_calculator.sv
// Top level of the sampling epoch time calculator.
//
// Requests arrive on req_valid/req_ready/req_data; each word yields exactly one
// result word on rsp_valid/rsp_ready/rsp_data, in order. A word of kind time
// gives the GPS week and time of week of an epoch index; kind index gives the
// first epoch at or after an event; kind count gives the epochs for a duration.
// The start time and rate are set through csr_we/csr_index/csr_wdata while
// idle; the user must ensure this, the block does not enforce it. Stages:
// two front stages, 13 divider stages of three quotient bits each, a rescale
// stage and the output register. One word is accepted per cycle unless the
// receiver stalls; the 39-bit restoring divider is fully pipelined. When the
// receiver stalls, words pack into empty stages and req_ready drops only once
// the pipeline is full; nothing is dropped. Synchronous reset empties the
// pipeline and sets start week and time of week to 0 and the rate to 1 Hz.
`timescale 1ns / 1ps
module sampling_epoch_time_calculator import setc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [49:0] csr_wdata
);

   csr_type csr_ff;
   div_type div_data  [DIV_STAGES+1];
   logic    div_valid [DIV_STAGES+1];
   logic    div_ready [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.start_week   <= 16'd0;
         csr_ff.start_tow_ns <= 50'd0;
         csr_ff.rate_hz      <= 6'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_WEEK: csr_ff.start_week   <= csr_wdata[15:0];
            CSR_START_TOW:  csr_ff.start_tow_ns <= csr_wdata;
            CSR_RATE:       csr_ff.rate_hz      <= csr_wdata[5:0];
            default: begin
               // Drop writes to an unused index.
               csr_ff <= csr_ff;
            end
         endcase
      end
   end

   setc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      setc_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_ready  (div_ready[g]),
         .in_data   (div_data[g]),
         .out_valid (div_valid[g+1]),
         .out_ready (div_ready[g+1]),
         .out_data  (div_data[g+1])
      );
   end

   setc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .in_valid  (div_valid[DIV_STAGES]),
      .in_ready  (div_ready[DIV_STAGES]),
      .in_data   (div_data[DIV_STAGES]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with output empty");

   a_week_only_for_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_week != 16'd0 |-> rsp_data.result_count == 39'd0)
      else $error("week and count both set");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

endmodule
